// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TCS_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define TCS_ASSERT(label, clk, rst_n, prop)
`define TCS_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif

`endif

// ===== design/tcs_pkg.sv =====
// Types and constants of the tensor stride contiguity check.
package tcs_pkg;

    localparam int MAX_RANK    = 8;
    localparam int IDX_W       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int SIZE_W      = 32;
    localparam int STRIDE_W    = 48;
    localparam int STRIDE_LO_W = 24;
    localparam int PLO_W       = STRIDE_LO_W + SIZE_W;
    localparam int PHI_W       = STRIDE_W - STRIDE_LO_W + SIZE_W + 1;
    localparam int PROD_W      = STRIDE_W + SIZE_W + 1;
    localparam int DIM_IDX_W   = 6;
    localparam int CONT_W      = 2;

    localparam logic [CNT_W-1:0] RANK_FULL = CNT_W'(MAX_RANK);

    typedef enum logic [CONT_W-1:0] {
        CONTIG_UNDET = 2'd0,
        CONTIG_NO    = 2'd1,
        CONTIG_YES   = 2'd2
    } t_contig;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// ===== design/tcs_if.sv =====
// Handshake interfaces for the dimension input and the result output.
interface tcs_in_if import tcs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [SIZE_W-1:0]          dim_size;
    logic signed [STRIDE_W-1:0] dim_stride;
    logic                       last_dim;

    modport source (output valid, output dim_size, output dim_stride, output last_dim,
                    input ready);
    modport sink (input valid, input dim_size, input dim_stride, input last_dim,
                  output ready);
endinterface

interface tcs_out_if import tcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DIM_IDX_W-1:0] dim_index;
    logic [CONT_W-1:0]    contiguity;
    logic                 last_result;
    logic                 rank_overflow;

    modport source (output valid, output dim_index, output contiguity,
                    output last_result, output rank_overflow, input ready);
    modport sink (input valid, input dim_index, input contiguity,
                  input last_result, input rank_overflow, output ready);
endinterface

// ===== design/tensor_contiguity_from_strides_top.sv =====
// Load one dimension per cycle while in the load state; the last dimension starts a walk,
// innermost first. The walk gives each stored dimension a memory read, then an evaluate.
// Results leave one per cycle while the output is ready, outermost first.
// Synchronous active-low reset clears control state; the size and stride
// memories are not cleared and only entries of the current tensor are read.
`include "assert_macros.svh"

module tensor_contiguity_from_strides_top import tcs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    tcs_in_if.sink     i_in,
    tcs_out_if.source  o_out
);

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_dims, n_dims;
    logic                       r_ovf, n_ovf;
    logic                       r_res_ovf, n_res_ovf;
    logic [IDX_W-1:0]           r_k, n_k;
    logic [IDX_W-1:0]           r_last_k, n_last_k;
    logic                       r_have_inner, n_have_inner;
    logic                       r_out_valid, n_out_valid;

    logic [DIM_IDX_W-1:0]       r_out_idx;
    t_contig                    r_out_cont;
    logic                       r_out_last;
    logic                       r_out_ovf;

    logic [SIZE_W-1:0]          m_size   [MAX_RANK];
    logic [STRIDE_W-1:0]        m_stride [MAX_RANK];
    logic [SIZE_W-1:0]          r_rd_size;
    logic signed [STRIDE_W-1:0] r_rd_stride;
    logic [SIZE_W-1:0]          r_in_size;
    logic [STRIDE_W-1:0]        r_in_stride;
    logic [PLO_W-1:0]           r_plo;
    logic signed [PHI_W-1:0]    r_phi;
    t_contig                    r_cont [MAX_RANK];

    logic                       w_in_acc;
    logic                       w_has_room;
    logic                       w_load_out;
    logic                       w_out_last;
    logic                       w_bcast;
    logic [PROD_W-1:0]          w_prod;
    logic                       w_match;
    t_contig                    w_eval_cont;

    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_has_room = (r_dims < RANK_FULL);
    assign w_load_out = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_out_last = (r_k == r_last_k);

    assign w_bcast = (r_rd_stride == '0) || (r_rd_size == SIZE_W'(1));
    assign w_prod  = {r_phi, STRIDE_LO_W'(0)} + PROD_W'(r_plo);
    assign w_match = (w_prod == PROD_W'(r_rd_stride));

    always_comb begin
        if (w_bcast) begin
            w_eval_cont = CONTIG_UNDET;
        end else if (!r_have_inner) begin
            w_eval_cont = (r_rd_stride == STRIDE_W'(1)) ? CONTIG_YES : CONTIG_NO;
        end else begin
            w_eval_cont = w_match ? CONTIG_YES : CONTIG_NO;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_dims       = r_dims;
        n_ovf        = r_ovf;
        n_res_ovf    = r_res_ovf;
        n_k          = r_k;
        n_last_k     = r_last_k;
        n_have_inner = r_have_inner;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_has_room) begin
                        n_dims = r_dims + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_dim) begin
                        n_state      = S_READ;
                        n_dims       = '0;
                        n_ovf        = 1'b0;
                        n_res_ovf    = r_ovf || !w_has_room;
                        n_last_k     = w_has_room ? r_dims[IDX_W-1:0] : IDX_W'(MAX_RANK - 1);
                        n_k          = n_last_k;
                        n_have_inner = 1'b0;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!w_bcast) begin
                    n_have_inner = 1'b1;
                end
                if (r_k == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    if (w_out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_dims       <= '0;
            r_ovf        <= 1'b0;
            r_res_ovf    <= 1'b0;
            r_k          <= '0;
            r_last_k     <= '0;
            r_have_inner <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dims       <= n_dims;
            r_ovf        <= n_ovf;
            r_res_ovf    <= n_res_ovf;
            r_k          <= n_k;
            r_last_k     <= n_last_k;
            r_have_inner <= n_have_inner;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_has_room) begin
            m_size[r_dims[IDX_W-1:0]]   <= i_in.dim_size;
            m_stride[r_dims[IDX_W-1:0]] <= i_in.dim_stride;
        end
        r_rd_size   <= m_size[r_k];
        r_rd_stride <= m_stride[r_k];
    end

    // The inner partner's product is formed in two halves while the next entry is read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_cont[r_k] <= w_eval_cont;
            if (!w_bcast) begin
                r_in_size   <= r_rd_size;
                r_in_stride <= r_rd_stride;
            end
        end
        r_plo <= r_in_stride[STRIDE_LO_W-1:0] * r_in_size;
        r_phi <= $signed(r_in_stride[STRIDE_W-1:STRIDE_LO_W]) * $signed({1'b0, r_in_size});
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_idx  <= DIM_IDX_W'(r_k);
            r_out_cont <= r_cont[r_k];
            r_out_last <= w_out_last;
            r_out_ovf  <= r_res_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.dim_index     = r_out_idx;
    assign o_out.contiguity    = r_out_cont;
    assign o_out.last_result   = r_out_last;
    assign o_out.rank_overflow = r_out_ovf;

    `TCS_ASSERT_NEXT(a_walk_ends_in_emit, i_clk, i_rst_n, r_state == S_EVAL && r_k == '0, r_state == S_EMIT)
    `TCS_ASSERT_NEXT(a_last_result_held, i_clk, i_rst_n, w_load_out && w_out_last, r_state == S_LOAD && r_out_valid && r_out_last)
    `TCS_ASSERT(a_count_clear_off_load, i_clk, i_rst_n, r_state != S_LOAD |-> r_dims == '0)

endmodule

// ===== tb/sv/tb_tensor_contiguity_from_strides_top.sv =====
// Testbench that drives tensor dimensions into the contiguity check and scores every result.
module tb_tensor_contiguity_from_strides_top import tcs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_OFFER    = 12;
    localparam int RANDOM_DIMS  = 130;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DIM_IDX_W-1:0] index;
        t_contig              contig;
        logic                 last;
        logic                 overflow;
    } t_dim_report;

    typedef struct {
        bit [SIZE_W-1:0]            size;
        logic signed [STRIDE_W-1:0] stride;
        bit                         last;
    } t_dim_item;

    class contiguity_checker;
        bit [SIZE_W-1:0]            sizes[MAX_RANK];
        logic signed [STRIDE_W-1:0] strides[MAX_RANK];
        int unsigned                loaded;
        bit                         dropped;
        t_dim_report                awaited[$];
        int                         mismatches;
        int                         results_seen;
        int                         tensors;
        int                         overflowed;
        int                         dims_offered;

        function void note_dim(bit [SIZE_W-1:0] size, logic signed [STRIDE_W-1:0] stride,
                               bit last);
            t_contig              verdict[MAX_RANK];
            logic signed [95:0]   outer_w;
            logic signed [95:0]   inner_w;
            logic signed [95:0]   size_w;
            int                   inner;
            bit                   have_inner;
            t_dim_report          rep;
            dims_offered++;
            if (loaded < MAX_RANK) begin
                sizes[loaded]   = size;
                strides[loaded] = stride;
                loaded++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            have_inner = 1'b0;
            inner      = 0;
            for (int k = int'(loaded) - 1; k >= 0; k--) begin
                if (strides[k] == 0 || sizes[k] == 1) begin
                    verdict[k] = CONTIG_UNDET;
                end else if (!have_inner) begin
                    verdict[k] = (strides[k] == 1) ? CONTIG_YES : CONTIG_NO;
                    have_inner = 1'b1;
                    inner      = k;
                end else begin
                    // The partner product is taken at full width so it can never wrap.
                    outer_w    = strides[k];
                    inner_w    = strides[inner];
                    size_w     = {64'd0, sizes[inner]};
                    verdict[k] = (outer_w == inner_w * size_w) ? CONTIG_YES : CONTIG_NO;
                    inner      = k;
                end
            end
            for (int k = 0; k < int'(loaded); k++) begin
                rep.index    = DIM_IDX_W'(k);
                rep.contig   = verdict[k];
                rep.last     = (k == int'(loaded) - 1);
                rep.overflow = dropped;
                awaited      = {awaited, rep};
            end
            tensors++;
            if (dropped) overflowed++;
            loaded  = 0;
            dropped = 1'b0;
        endfunction

        function void check_result(logic [DIM_IDX_W-1:0] index, logic [CONT_W-1:0] contig,
                                   logic last, logic overflow);
            t_dim_report want;
            results_seen++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: index %0d contiguity %0d last %0b overflow %0b",
                             index, contig, last, overflow);
                return;
            end
            want = awaited.pop_front();
            if (index !== want.index || contig !== want.contig || last !== want.last ||
                overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Mismatch: expected idx %0d cont %0d last %0b ovf %0b, %s%0d %0d %0b %0b",
                             want.index, want.contig, want.last, want.overflow,
                             "got ", index, contig, last, overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tcs_in_if  in_if();
    tcs_out_if out_if();

    tensor_contiguity_from_strides_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    contiguity_checker contig_sb;
    t_dim_item         stimulus[$];
    bit                calm_in;
    bit                calm_out;
    int                stall_left;
    int                cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial out_if.ready = 1'b0;

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) calm_out = ~calm_out;
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            if (!calm_out && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            contig_sb.check_result(out_if.dim_index, out_if.contiguity,
                                   out_if.last_result, out_if.rank_overflow);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_dim(bit [SIZE_W-1:0] size, logic signed [STRIDE_W-1:0] stride,
                                    bit last);
        t_dim_item item;
        item.size   = size;
        item.stride = stride;
        item.last   = last;
        stimulus    = {stimulus, item};
    endfunction

    function automatic int add_random_tensor();
        bit [SIZE_W-1:0]            sz[MAX_OFFER];
        logic signed [STRIDE_W-1:0] st[MAX_OFFER];
        longint                     acc;
        int                         rank;
        bit                         neg;
        bit                         well_formed;
        rank        = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_RANK + 1, MAX_OFFER)
                                                   : $urandom_range(1, MAX_RANK);
        well_formed = ($urandom_range(0, 9) < 7);
        neg         = ($urandom_range(0, 3) == 0);
        acc         = 1;
        for (int k = rank - 1; k >= 0; k--) begin
            case ($urandom_range(0, 19))
                0, 1:    sz[k] = 1;
                2:       sz[k] = 0;
                3:       sz[k] = $urandom();
                default: sz[k] = $urandom_range(2, 16);
            endcase
            if (well_formed) begin
                st[k] = neg ? STRIDE_W'(-acc) : STRIDE_W'(acc);
                case ($urandom_range(0, 15))
                    0:       st[k] = st[k] + 1;
                    1:       st[k] = -st[k];
                    2:       st[k] = 0;
                    default: ;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       st[k] = STRIDE_W'({$urandom(), $urandom()});
                    1:       st[k] = STRIDE_W'(int'($urandom_range(0, 40)) - 20);
                    default: st[k] = STRIDE_W'(acc);
                endcase
            end
            if (sz[k] > 1) acc = acc * longint'(sz[k]);
        end
        for (int k = 0; k < rank; k++) add_dim(sz[k], st[k], k == rank - 1);
        return (rank > MAX_RANK) ? MAX_RANK : rank;
    endfunction

    task automatic drive_dims();
        t_dim_item item;
        int        gap;
        while (stimulus.size() > 0) begin
            item = stimulus.pop_front();
            in_if.valid      <= 1'b1;
            in_if.dim_size   <= item.size;
            in_if.dim_stride <= item.stride;
            in_if.last_dim   <= item.last;
            do @(posedge i_clk); while (in_if.ready !== 1'b1);
            contig_sb.note_dim(item.size, item.stride, item.last);
            if (item.last) calm_in = ($urandom_range(0, 4) == 0);
            gap = calm_in ? 0 : pick_gap();
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b0;
    endtask

    initial begin
        int random_dims;
        contig_sb        = new();
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.dim_size   = '0;
        in_if.dim_stride = '0;
        in_if.last_dim   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_dim(5, 1, 1'b1);
        add_dim(32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1'b1);
        add_dim(4, 15, 1'b0);
        add_dim(3, 5, 1'b0);
        add_dim(5, 1, 1'b1);
        add_dim(7, 3, 1'b0);
        add_dim(1, 9, 1'b0);
        add_dim(3, 0, 1'b0);
        add_dim(3, 1, 1'b1);
        add_dim(1, 48'sh8000_0000_0000, 1'b0);
        add_dim(6, 0, 1'b1);
        add_dim(2, 8, 1'b0);
        add_dim(0, 4, 1'b1);
        add_dim(4, 6, 1'b0);
        add_dim(3, -2, 1'b0);
        add_dim(2, -1, 1'b1);
        add_dim(3, 48'sh0000_FFFF_FFFF, 1'b0);
        add_dim(32'hFFFF_FFFF, 1, 1'b1);
        for (int k = 0; k < MAX_RANK; k++) add_dim(2, 48'sd1 <<< (MAX_RANK - 1 - k), 1'b0);
        add_dim(2, 5, 1'b1);
        drive_dims();

        random_dims = 0;
        while (random_dims < RANDOM_DIMS) random_dims += add_random_tensor();
        drive_dims();

        while (contig_sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4 * MAX_RANK) @(posedge i_clk);

        $display("Covered %0d tensors from %0d offered dimensions, %0d of them over the limit.",
                 contig_sb.tensors, contig_sb.dims_offered, contig_sb.overflowed);
        $display("Compared %0d results, %0d mismatched, %0d still awaited.",
                 contig_sb.results_seen, contig_sb.mismatches, contig_sb.awaited.size());
        if (contig_sb.mismatches == 0 && contig_sb.awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
